### rtl/rgbconv_pkg.sv
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Shared types and constants of the RGB 3x3 convolution unit.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int PIX_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SIZE_W    = 9;
  localparam int ACC_W     = 20;

  // Position of a tap inside the 3x3 window, per axis.
  localparam logic [1:0] TAP_FIRST = 2'd0;
  localparam logic [1:0] TAP_MID   = 2'd1;
  localparam logic [1:0] TAP_LAST  = 2'd2;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS    = 3'd0,
    REG_FRAME_COLS    = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       write_pixel;
    logic       load_center;
    logic       issue;
    logic [1:0] tap_row;
    logic [1:0] tap_col;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### rtl/rgbconv_frame_mem.sv
// ----------------------------------------------------------------------------
// rgbconv_frame_mem
// Single-port frame store with registered read data.
// ----------------------------------------------------------------------------
module rgbconv_frame_mem (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          we_i,
  input  logic [rgbconv_pkg::ADDR_W-1:0] addr_i,
  input  logic [rgbconv_pkg::PIX_W-1:0]  wdata_i,
  output logic [rgbconv_pkg::PIX_W-1:0]  rdata_o
);

  logic [rgbconv_pkg::PIX_W-1:0] mem [rgbconv_pkg::DEPTH];
  logic [rgbconv_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rgbconv_ctrl.sv
// ----------------------------------------------------------------------------
// rgbconv_ctrl
// Sequencer that walks the nine window taps of a read word.
// ----------------------------------------------------------------------------
module rgbconv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_action_i,
  output logic                 in_ready_o,
  input  rgbconv_pkg::status_t status_i,
  output rgbconv_pkg::cmd_t    cmd_o
);

  rgbconv_pkg::state_e state_q, state_d;
  logic [1:0] tap_row_q, tap_row_d;
  logic [1:0] tap_col_q, tap_col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rgbconv_pkg::ST_IDLE;
      tap_row_q <= rgbconv_pkg::TAP_FIRST;
      tap_col_q <= rgbconv_pkg::TAP_FIRST;
    end else begin
      state_q   <= state_d;
      tap_row_q <= tap_row_d;
      tap_col_q <= tap_col_d;
    end
  end

  // Next state and tap counters.
  always_comb begin
    state_d   = state_q;
    tap_row_d = tap_row_q;
    tap_col_d = tap_col_q;
    case (state_q)
      rgbconv_pkg::ST_IDLE: begin
        tap_row_d = rgbconv_pkg::TAP_FIRST;
        tap_col_d = rgbconv_pkg::TAP_FIRST;
        if (in_valid_i && in_action_i == rgbconv_pkg::ACT_READ) begin
          state_d = rgbconv_pkg::ST_FETCH;
        end
      end
      rgbconv_pkg::ST_FETCH: begin
        if (tap_col_q == rgbconv_pkg::TAP_LAST) begin
          tap_col_d = rgbconv_pkg::TAP_FIRST;
          if (tap_row_q == rgbconv_pkg::TAP_LAST) begin
            state_d = rgbconv_pkg::ST_DRAIN;
          end else begin
            tap_row_d = tap_row_q + 2'd1;
          end
        end else begin
          tap_col_d = tap_col_q + 2'd1;
        end
      end
      rgbconv_pkg::ST_DRAIN: begin
        state_d = rgbconv_pkg::ST_FINISH;
      end
      rgbconv_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = rgbconv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rgbconv_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.tap_row     = tap_row_q;
    cmd_o.tap_col     = tap_col_q;
    case (state_q)
      rgbconv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.write_pixel = (in_action_i == rgbconv_pkg::ACT_LOAD);
          cmd_o.load_center = (in_action_i == rgbconv_pkg::ACT_READ);
        end
      end
      rgbconv_pkg::ST_FETCH: begin
        cmd_o.issue = 1'b1;
      end
      rgbconv_pkg::ST_FINISH: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o.issue = 1'b0;
      end
    endcase
  end

  a_first_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_center |=> cmd_o.issue && cmd_o.tap_row == rgbconv_pkg::TAP_FIRST &&
                          cmd_o.tap_col == rgbconv_pkg::TAP_FIRST)
    else $error("window walk did not start at the top left tap");

  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue && cmd_o.tap_row == rgbconv_pkg::TAP_LAST &&
    cmd_o.tap_col == rgbconv_pkg::TAP_LAST |=> !cmd_o.issue ##1 !in_ready_o)
    else $error("window walk did not stop after the last tap");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded over a word not yet taken");

endmodule

### rtl/rgbconv_datapath.sv
// ----------------------------------------------------------------------------
// rgbconv_datapath
// Configuration registers, tap addressing, multiply-accumulate and output word.
// ----------------------------------------------------------------------------
module rgbconv_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgbconv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgbconv_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [rgbconv_pkg::ROW_W-1:0]     in_row_i,
  input  logic [rgbconv_pkg::COL_W-1:0]     in_col_i,
  input  logic [rgbconv_pkg::PIX_W-1:0]     in_pixel_i,
  input  rgbconv_pkg::cmd_t                 cmd_i,
  output rgbconv_pkg::status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rgbconv_pkg::PIX_W-1:0]     out_pixel_o
);

  localparam int RW = rgbconv_pkg::ROW_W;
  localparam int CW = rgbconv_pkg::COL_W;
  localparam int AW = rgbconv_pkg::ACC_W;

  logic [rgbconv_pkg::SIZE_W-1:0] rows_q, cols_q;
  logic [rgbconv_pkg::CFG_W-1:0]  ktop_q, kmid_q, kbot_q;
  logic [RW-1:0] last_row, cr_q, nb_row;
  logic [CW-1:0] last_col, cc_q, nb_col;
  logic          rd_valid_q;
  logic [1:0]    rd_row_q, rd_col_q;
  logic [rgbconv_pkg::PIX_W-1:0] mem_rdata;
  logic [rgbconv_pkg::CFG_W-1:0] kernel_row;
  logic signed [7:0]  weight;
  logic signed [AW-1:0] acc_q [3];
  logic signed [AW-1:0] acc_d [3];
  logic signed [16:0]  prod [3];
  logic          out_valid_q;
  logic [rgbconv_pkg::PIX_W-1:0] out_pixel_q;
  logic [rgbconv_pkg::PIX_W-1:0] clamped;

  // Last usable index: a size of zero acts as one, an oversized one as the maximum.
  function automatic logic [RW-1:0] last_row_of(logic [rgbconv_pkg::SIZE_W-1:0] n);
    if (n == '0) return '0;
    if (n > rgbconv_pkg::SIZE_W'(rgbconv_pkg::MAX_ROWS)) return RW'(rgbconv_pkg::MAX_ROWS - 1);
    return RW'(n - 1'b1);
  endfunction

  function automatic logic [CW-1:0] last_col_of(logic [rgbconv_pkg::SIZE_W-1:0] n);
    if (n == '0) return '0;
    if (n > rgbconv_pkg::SIZE_W'(rgbconv_pkg::MAX_COLS)) return CW'(rgbconv_pkg::MAX_COLS - 1);
    return CW'(n - 1'b1);
  endfunction

  function automatic logic [7:0] clamp_pixel(logic signed [AW-1:0] s);
    if (s[AW-1]) return 8'd0;
    if (|s[AW-2:8]) return 8'hFF;
    return s[7:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= rgbconv_pkg::SIZE_W'(256);
      cols_q <= rgbconv_pkg::SIZE_W'(256);
      ktop_q <= '0;
      kmid_q <= rgbconv_pkg::CFG_W'(256);
      kbot_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgbconv_pkg::REG_FRAME_ROWS:    rows_q <= cfg_data_i[rgbconv_pkg::SIZE_W-1:0];
        rgbconv_pkg::REG_FRAME_COLS:    cols_q <= cfg_data_i[rgbconv_pkg::SIZE_W-1:0];
        rgbconv_pkg::REG_KERNEL_TOP:    ktop_q <= cfg_data_i;
        rgbconv_pkg::REG_KERNEL_MIDDLE: kmid_q <= cfg_data_i;
        rgbconv_pkg::REG_KERNEL_BOTTOM: kbot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign last_row = last_row_of(rows_q);
  assign last_col = last_col_of(cols_q);

  // The center itself is clamped, so a read outside the frame reads its edge.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_center) begin
      cr_q <= (in_row_i > last_row) ? last_row : in_row_i;
      cc_q <= (in_col_i > last_col) ? last_col : in_col_i;
    end
  end

  always_comb begin
    case (cmd_i.tap_row)
      rgbconv_pkg::TAP_FIRST: nb_row = (cr_q == '0) ? cr_q : cr_q - 1'b1;
      rgbconv_pkg::TAP_LAST:  nb_row = (cr_q == last_row) ? cr_q : cr_q + 1'b1;
      default:                nb_row = cr_q;
    endcase
    case (cmd_i.tap_col)
      rgbconv_pkg::TAP_FIRST: nb_col = (cc_q == '0) ? cc_q : cc_q - 1'b1;
      rgbconv_pkg::TAP_LAST:  nb_col = (cc_q == last_col) ? cc_q : cc_q + 1'b1;
      default:                nb_col = cc_q;
    endcase
  end

  rgbconv_frame_mem u_mem (
    .clk_i   (clk_i),
    .en_i    (cmd_i.issue | cmd_i.write_pixel),
    .we_i    (cmd_i.write_pixel),
    .addr_i  (cmd_i.issue ? {nb_row, nb_col} : {in_row_i, in_col_i}),
    .wdata_i (in_pixel_i),
    .rdata_o (mem_rdata)
  );

  // The tap position travels alongside the read so the weight lines up with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= cmd_i.tap_row;
    rd_col_q <= cmd_i.tap_col;
  end

  always_comb begin
    case (rd_row_q)
      rgbconv_pkg::TAP_FIRST: kernel_row = ktop_q;
      rgbconv_pkg::TAP_MID:   kernel_row = kmid_q;
      default:                kernel_row = kbot_q;
    endcase
    case (rd_col_q)
      rgbconv_pkg::TAP_FIRST: weight = $signed(kernel_row[7:0]);
      rgbconv_pkg::TAP_MID:   weight = $signed(kernel_row[15:8]);
      default:                weight = $signed(kernel_row[23:16]);
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]  = $signed({1'b0, mem_rdata[8*k +: 8]}) * weight;
      acc_d[k] = acc_q[k] + AW'(prod[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.load_center) begin
        acc_q[k] <= '0;
      end else if (rd_valid_q) begin
        acc_q[k] <= acc_d[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clamped[8*k +: 8] = clamp_pixel(acc_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pixel_q <= clamped;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_pixel_o       = out_pixel_q;

  a_read_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(cmd_i.issue))
    else $error("read data marked valid without a tap read");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_o && out_pixel_o == $past(clamped))
    else $error("loaded result not presented");

endmodule

### rtl/rgb_3x3_convolution_replicate_edge_unit.sv
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_replicate_edge_unit
// Load word: frame store written at acceptance, no result.
// Read word: nine tap reads on the single store port, one drain step and
// one output load, which waits while the output stalls; the next word is
// accepted only after the output load. Reset clears control and the
// configuration registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_replicate_edge_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgbconv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgbconv_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_row, pixel_col, in_red, in_green, in_blue
  input  logic [39:0]                       s_axis_tdata,
  // action
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_red, out_green, out_blue
  output logic [23:0]                       m_axis_tdata
);

  rgbconv_pkg::cmd_t    cmd;
  rgbconv_pkg::status_t status;

  rgbconv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rgbconv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_row_i    (s_axis_tdata[7:0]),
    .in_col_i    (s_axis_tdata[15:8]),
    .in_pixel_i  (s_axis_tdata[39:16]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata)
  );

endmodule

### verif/rgb_3x3_convolution_replicate_edge_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_replicate_edge_unit_tb
// Self-checking bench for the RGB 3x3 convolution unit. Load and read words
// stream in with random gaps and output stalls; a local copy of the frame
// store and registers predicts each filtered pixel, and every result word is
// checked color by color. Phases cover degenerate, oversized and small frame
// sizes with extreme, identity and random kernels.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_replicate_edge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbconv_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          PHASE_ITEMS    = 116;
  localparam logic [2:0]  REG_SPARE_LO   = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;

  typedef struct packed {
    action_e    act;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] col;
    logic [7:0] row;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // pixel_row, pixel_col, in_red, in_green, in_blue
  logic [39:0]          s_axis_tdata = '0;
  // action
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // out_red, out_green, out_blue
  logic [23:0]          m_axis_tdata;

  rgb_3x3_convolution_replicate_edge_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the frame store and registers, updated as words are accepted.
  logic [PIX_W-1:0] img_mem [0:DEPTH-1];
  logic [8:0]       frame_rows_q = 9'd256;
  logic [8:0]       frame_cols_q = 9'd256;
  logic [23:0]      kern_q [0:2] = '{24'd0, 24'd256, 24'd0};

  // Entries that the queued stimulus has written; reads never touch others.
  bit               gen_written [0:DEPTH-1];

  pixel_cmd_t word_q[$];
  rgb_t       filt_q[$];
  int         words_queued = 0;
  int         words_taken  = 0;
  int         err_cnt      = 0;
  int         idle_cyc     = 0;
  bit         in_taken     = 1'b0;
  bit         stall_on     = 1'b1;
  int         src_gap      = 0;
  int         sink_gap     = 0;
  pixel_cmd_t cur_word;

  task automatic report_err(string msg);
    $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int active_span(logic [8:0] regv, int max_v);
    if (regv == 9'd0) return 1;
    if (regv > max_v) return max_v;
    return int'(regv);
  endfunction

  function automatic int clip_idx(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  function automatic rgb_t filter_at(logic [7:0] row, logic [7:0] col);
    int               nrows, ncols, cr, cc, r, c, w;
    int               acc [0:2];
    logic [PIX_W-1:0] px;
    rgb_t             res;
    nrows = active_span(frame_rows_q, MAX_ROWS);
    ncols = active_span(frame_cols_q, MAX_COLS);
    cr = clip_idx(int'(row), nrows);
    cc = clip_idx(int'(col), ncols);
    acc = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      r = clip_idx(cr + i - 1, nrows);
      for (int j = 0; j < 3; j++) begin
        c = clip_idx(cc + j - 1, ncols);
        px = img_mem[r * MAX_COLS + c];
        w = $signed(kern_q[i][8*j +: 8]);
        for (int k = 0; k < 3; k++) acc[k] += int'(px[8*k +: 8]) * w;
      end
    end
    for (int k = 0; k < 3; k++) acc[k] = (acc[k] < 0) ? 0 : (acc[k] > 255) ? 255 : acc[k];
    res.red   = acc[0][7:0];
    res.green = acc[1][7:0];
    res.blue  = acc[2][7:0];
    return res;
  endfunction

  // Monitor, input acceptance and watchdog share one clocked process so that
  // results and new expectations are handled in a fixed order.
  always @(posedge clk_i) begin
    rgb_t       got, want;
    logic [7:0] r, c;
    bit         moved;
    if (rst_ni) begin
      moved = cfg_we_i;
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got = m_axis_tdata;
        if (filt_q.size() == 0) begin
          report_err($sformatf("result word %h with nothing expected", m_axis_tdata));
        end else begin
          want = filt_q.pop_front();
          if (got.red !== want.red)
            report_err($sformatf("red got %0d want %0d", got.red, want.red));
          if (got.green !== want.green)
            report_err($sformatf("green got %0d want %0d", got.green, want.green));
          if (got.blue !== want.blue)
            report_err($sformatf("blue got %0d want %0d", got.blue, want.blue));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        in_taken = 1'b1;
        words_taken++;
        r = s_axis_tdata[7:0];
        c = s_axis_tdata[15:8];
        if (s_axis_tuser == ACT_READ) begin
          filt_q.push_back(filter_at(r, c));
        end else begin
          img_mem[int'(r) * MAX_COLS + int'(c)] = s_axis_tdata[39:16];
        end
      end
      idle_cyc = moved ? 0 : idle_cyc + 1;
      if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("rgb_3x3_convolution_replicate_edge_unit_tb: errors");
        $finish;
      end
    end
  end

  // Word driver: presents queued words with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (word_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 19) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_word = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_word.act;
        s_axis_tdata  <= {cur_word.blue, cur_word.green, cur_word.red,
                          cur_word.col, cur_word.row};
      end
    end
  end

  // Result sink: random stall bursts on tready.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_FRAME_ROWS:    frame_rows_q = data[8:0];
      REG_FRAME_COLS:    frame_cols_q = data[8:0];
      REG_KERNEL_TOP:    kern_q[0] = data;
      REG_KERNEL_MIDDLE: kern_q[1] = data;
      REG_KERNEL_BOTTOM: kern_q[2] = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || filt_q.size() != 0) @(negedge clk_i);
    // A load is written to the frame store as it is taken, so none stays in flight inside the block.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_color();
    if ($urandom_range(0, 4) == 0) return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] rand_kernel_row();
    logic [23:0] k;
    int          w;
    for (int j = 0; j < 3; j++) begin
      if ($urandom_range(0, 3) == 0) begin
        k[8*j +: 8] = 8'($urandom);
      end else begin
        w = $urandom_range(0, 6) - 3;
        k[8*j +: 8] = w[7:0];
      end
    end
    return k;
  endfunction

  function automatic logic [7:0] pick_coord(int lim);
    int v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = lim - 1;
      2:       v = $urandom_range(0, lim - 1);
      3, 4:    v = $urandom_range(0, (lim > 6) ? 5 : lim - 1);
      default: v = (lim < 256) ? $urandom_range(lim, 255) : $urandom_range(252, 255);
    endcase
    return v[7:0];
  endfunction

  function automatic void push_word(action_e act, logic [7:0] row, logic [7:0] col,
                                    logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    pixel_cmd_t w;
    w.act   = act;
    w.row   = row;
    w.col   = col;
    w.red   = red;
    w.green = green;
    w.blue  = blue;
    word_q.push_back(w);
    words_queued++;
    if (act == ACT_LOAD) gen_written[int'(row) * MAX_COLS + int'(col)] = 1'b1;
  endfunction

  // Loads every unwritten pixel of the clamped window first, then reads.
  function automatic void add_read(logic [7:0] row, logic [7:0] col);
    int nrows, ncols, cr, cc, r, c;
    nrows = active_span(frame_rows_q, MAX_ROWS);
    ncols = active_span(frame_cols_q, MAX_COLS);
    cr = clip_idx(int'(row), nrows);
    cc = clip_idx(int'(col), ncols);
    for (int i = -1; i <= 1; i++) begin
      for (int j = -1; j <= 1; j++) begin
        r = clip_idx(cr + i, nrows);
        c = clip_idx(cc + j, ncols);
        if (!gen_written[r * MAX_COLS + c])
          push_word(ACT_LOAD, r[7:0], c[7:0], rand_color(), rand_color(), rand_color());
      end
    end
    push_word(ACT_READ, row, col, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic run_phase(int rows, int cols, logic [23:0] k_top, logic [23:0] k_mid,
                           logic [23:0] k_bot, int n_items);
    int         start, nrows, ncols;
    logic [7:0] r, c;
    wait_idle();
    write_reg(REG_FRAME_ROWS, {15'($urandom), rows[8:0]});
    write_reg(REG_FRAME_COLS, {15'($urandom), cols[8:0]});
    write_reg(REG_KERNEL_TOP, k_top);
    write_reg(REG_KERNEL_MIDDLE, k_mid);
    write_reg(REG_KERNEL_BOTTOM, k_bot);
    for (int x = REG_SPARE_LO; x <= REG_SPARE_HI; x++) write_reg(3'(x), 24'($urandom));
    nrows = active_span(frame_rows_q, MAX_ROWS);
    ncols = active_span(frame_cols_q, MAX_COLS);
    start = words_queued;
    while (words_queued - start < n_items) begin
      if ($urandom_range(0, 9) < 3) begin
        // Stray load, possibly outside the active frame.
        r = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_coord(nrows);
        c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_coord(ncols);
        push_word(ACT_LOAD, r, c, rand_color(), rand_color(), rand_color());
      end else begin
        add_read(pick_coord(nrows), pick_coord(ncols));
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: full frame, identity kernel, corner pixels.
    push_word(ACT_LOAD, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    push_word(ACT_LOAD, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00);
    add_read(8'd0, 8'd0);
    add_read(8'd255, 8'd255);
    add_read(8'd0, 8'd255);
    add_read(8'd255, 8'd0);

    run_phase(256, 256, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(), PHASE_ITEMS);
    // A zero size acts as a single row or column.
    run_phase(0, 0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, PHASE_ITEMS);
    run_phase(1, 256, rand_kernel_row(), 24'hFFFFFF, rand_kernel_row(), PHASE_ITEMS);
    // Sizes above the store dimensions fall back to the full store.
    run_phase(511, 300, 24'h808080, 24'h7F7F7F, 24'h000000, PHASE_ITEMS);
    run_phase($urandom_range(2, 12), $urandom_range(2, 12), rand_kernel_row(),
              rand_kernel_row(), rand_kernel_row(), PHASE_ITEMS);
    run_phase($urandom_range(1, 20), 1, rand_kernel_row(), rand_kernel_row(),
              rand_kernel_row(), PHASE_ITEMS);
    wait_idle();
    stall_on = 1'b0;
    run_phase($urandom_range(2, 20), $urandom_range(2, 20), rand_kernel_row(),
              rand_kernel_row(), rand_kernel_row(), PHASE_ITEMS);
    run_phase($urandom_range(2, 8), $urandom_range(2, 8), 24'h010101, 24'h010101,
              24'h010101, PHASE_ITEMS);
    wait_idle();

    if (err_cnt == 0 && filt_q.size() == 0) begin
      $display("rgb_3x3_convolution_replicate_edge_unit_tb: clean");
    end else begin
      $display("rgb_3x3_convolution_replicate_edge_unit_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rgbconv_pkg.sv
rtl/rgbconv_frame_mem.sv
rtl/rgbconv_ctrl.sv
rtl/rgbconv_datapath.sv
rtl/rgb_3x3_convolution_replicate_edge_unit.sv
verif/rgb_3x3_convolution_replicate_edge_unit_tb.sv
